>>> rtl/tsm_pkg.sv
package tsm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] CFG_HOLD_FRAMES = 2'd0;
    localparam logic [1:0] CFG_MOVE_TH     = 2'd1;
    localparam logic [1:0] CFG_IDLE_TH     = 2'd2;
    localparam logic [1:0] CFG_CAL_WINDOW  = 2'd3;

    localparam logic [7:0]  HOLD_FRAMES_RST = 8'd30;
    localparam logic [14:0] MOVE_TH_RST     = 15'd164;
    localparam logic [14:0] IDLE_TH_RST     = 15'd1638;
    localparam logic [15:0] CAL_WINDOW_RST  = 16'd80;

    // inverse cordic gain, Q16
    localparam logic signed [31:0] GAIN_INV_Q16 = 32'sd39797;

    typedef struct packed {
        logic        operation;
        logic        connected;
        logic        button_pressed;
        logic [15:0] calibration_age;
        logic [63:0] body_rotation;
        logic [63:0] head_rotation;
        logic [47:0] velocity;
        logic [31:0] stick_in;
    } t_in_word;

    typedef struct packed {
        logic               override;
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
    } t_out_word;

    // arctan(2^-i) as a 32 bit binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat14(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd16384) begin
            r = 16'sd16384;
        end else if (v < -32'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage

>>> rtl/treadmill_stick_mapper_core.sv
// update: yaw, vectoring, rotate, matrix, rotate, magnitude, finish, plus square
// root and divide when clamped; while calibrating, yaw and vectoring twice; motion
// state cleared if disconnected; a query loads the output register once it is
// free; one word in flight at a time; throughput is set by the single cordic
// stage, the shared multiplier and bit-serial square root and divider; synchronous
// active-low reset clears control, held state and loads the register defaults
module treadmill_stick_mapper_core #(
    parameter int CORDIC_STEPS = tsm_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tsm_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tsm_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import tsm_pkg::*;

    localparam int ITW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [ITW-1:0] ITER_LAST = ITW'(CORDIC_STEPS - 1);
    localparam logic signed [31:0] ANG_Q = 32'sh4000_0000;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_QOUT = 11'b000_0000_0010,
        S_YAW  = 11'b000_0000_0100,
        S_VEC  = 11'b000_0000_1000,
        S_ROT  = 11'b000_0001_0000,
        S_GAIN = 11'b000_0010_0000,
        S_MAT  = 11'b000_0100_0000,
        S_MAG  = 11'b000_1000_0000,
        S_SQRT = 11'b001_0000_0000,
        S_DIV  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

    t_state    r_state;
    t_in_word  r_in;
    t_out_word r_out, r_pend;
    logic      r_out_valid;

    logic [7:0]  r_hold_frames;
    logic [14:0] r_move_th, r_idle_th;
    logic [15:0] r_cal_win;

    logic [15:0]        r_yaw_corr;
    logic signed [15:0] r_held_x, r_held_y;
    logic               r_moving, r_conn;
    logic [7:0]         r_stop;

    logic r_cal, r_ysel, r_rot2, r_divz, r_vzero;
    logic [4:0]     r_cnt;
    logic [ITW-1:0] r_iter;

    logic signed [35:0] r_cx, r_cy;
    logic [31:0]        r_ang, r_yb, r_yh;
    logic signed [65:0] r_prod;
    logic signed [61:0] r_acc0, r_acc1;
    logic signed [33:0] r_c00, r_c01, r_c02, r_c20, r_c21, r_c22;
    logic signed [31:0] r_vx, r_vz, r_ox, r_oz;
    logic [62:0]        r_mag, r_sq_n, r_sq_r, r_sq_b;
    logic [46:0]        r_dv_n, r_dv_d;
    logic [15:0]        r_q;

    // quaternion and velocity components
    logic [63:0]        yq;
    logic signed [15:0] yq_x, yq_y, yq_z, yq_w;
    logic signed [15:0] bq_x, bq_y, bq_z, bq_w;
    logic signed [15:0] vel_x, vel_y, vel_z;

    assign yq    = r_ysel ? r_in.head_rotation : r_in.body_rotation;
    assign yq_x  = $signed(yq[15:0]);
    assign yq_y  = $signed(yq[31:16]);
    assign yq_z  = $signed(yq[47:32]);
    assign yq_w  = $signed(yq[63:48]);
    assign bq_x  = $signed(r_in.body_rotation[15:0]);
    assign bq_y  = $signed(r_in.body_rotation[31:16]);
    assign bq_z  = $signed(r_in.body_rotation[47:32]);
    assign bq_w  = $signed(r_in.body_rotation[63:48]);
    assign vel_x = $signed(r_in.velocity[15:0]);
    assign vel_y = $signed(r_in.velocity[31:16]);
    assign vel_z = $signed(r_in.velocity[47:32]);

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [33:0] p2;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_YAW: begin
                case (r_cnt)
                    5'd0: begin mul_a = 34'(yq_w); mul_b = 32'(yq_y); end
                    5'd1: begin mul_a = 34'(yq_x); mul_b = 32'(yq_z); end
                    5'd2: begin mul_a = 34'(yq_y); mul_b = 32'(yq_y); end
                    5'd3: begin mul_a = 34'(yq_x); mul_b = 32'(yq_x); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_GAIN: begin
                mul_a = (r_cnt == 5'd0) ? 34'(r_cx) : 34'(r_cy);
                mul_b = GAIN_INV_Q16;
            end
            S_MAT: begin
                case (r_cnt)
                    5'd0:  begin mul_a = 34'(bq_x); mul_b = 32'(bq_x); end
                    5'd1:  begin mul_a = 34'(bq_y); mul_b = 32'(bq_y); end
                    5'd2:  begin mul_a = 34'(bq_z); mul_b = 32'(bq_z); end
                    5'd3:  begin mul_a = 34'(bq_x); mul_b = 32'(bq_y); end
                    5'd4:  begin mul_a = 34'(bq_x); mul_b = 32'(bq_z); end
                    5'd5:  begin mul_a = 34'(bq_y); mul_b = 32'(bq_z); end
                    5'd6:  begin mul_a = 34'(bq_w); mul_b = 32'(bq_x); end
                    5'd7:  begin mul_a = 34'(bq_w); mul_b = 32'(bq_y); end
                    5'd8:  begin mul_a = 34'(bq_w); mul_b = 32'(bq_z); end
                    5'd9:  begin mul_a = r_c00; mul_b = r_vx; end
                    5'd10: begin mul_a = r_c01; mul_b = 32'(vel_y) <<< 8; end
                    5'd11: begin mul_a = r_c02; mul_b = r_vz; end
                    5'd12: begin mul_a = r_c20; mul_b = r_vx; end
                    5'd13: begin mul_a = r_c21; mul_b = 32'(vel_y) <<< 8; end
                    5'd14: begin mul_a = r_c22; mul_b = r_vz; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_MAG: begin
                mul_a = (r_cnt == 5'd0) ? 34'(r_vx) : 34'(r_vz);
                mul_b = (r_cnt == 5'd0) ? r_vx : r_vz;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 66'(mul_a) * 66'(mul_b);
    assign p2    = $signed({r_prod[32:0], 1'b0});

    // cordic stage, one iteration per cycle
    logic signed [35:0] cx_sh, cy_sh, c_nx, c_ny;
    logic [31:0]        atan_t, c_na, vang;
    logic               dir_a;

    assign cx_sh  = r_cx >>> r_iter;
    assign cy_sh  = r_cy >>> r_iter;
    assign atan_t = atan_entry(5'(r_iter));
    assign dir_a  = (r_state == S_VEC) ? !(r_cy > 36'sd0) : !r_ang[31];
    assign c_nx   = dir_a ? (r_cx - cy_sh) : (r_cx + cy_sh);
    assign c_ny   = dir_a ? (r_cy + cx_sh) : (r_cy - cx_sh);
    assign c_na   = dir_a ? (r_ang - atan_t) : (r_ang + atan_t);
    assign vang   = r_vzero ? r_ang : c_na;

    // rotation start: fold the angle into +-90 degrees
    logic signed [35:0] ld_x, ld_y, rot_x, rot_y;
    logic [31:0]        ld_ang, rot_ang;
    logic               ld_fold;

    always_comb begin
        if (r_state == S_VEC) begin
            ld_x   = 36'(vel_x) <<< 8;
            ld_y   = 36'(vel_z) <<< 8;
            ld_ang = {r_yaw_corr, 16'h0000};
        end else begin
            ld_x   = 36'(r_acc0 >>> 28);
            ld_y   = 36'(r_acc1 >>> 28);
            ld_ang = 32'd0 - r_yh;
        end
        ld_fold = ($signed(ld_ang) > ANG_Q) || ($signed(ld_ang) < -ANG_Q);
        rot_x   = ld_fold ? -ld_x : ld_x;
        rot_y   = ld_fold ? -ld_y : ld_y;
        rot_ang = ld_fold ? (ld_ang ^ 32'h8000_0000) : ld_ang;
    end

    // vectoring start from the yaw products
    logic signed [35:0] yaw_num, yaw_den;
    assign yaw_num = 36'(r_acc0) <<< 1;
    assign yaw_den = 36'sh1000_0000 - (36'(r_acc1) <<< 1);

    // square root step
    logic [62:0] sq_t, sq_r_next;
    logic        sq_ge;
    assign sq_t      = r_sq_r + r_sq_b;
    assign sq_ge     = r_sq_n >= sq_t;
    assign sq_r_next = sq_ge ? ((r_sq_r >> 1) + r_sq_b) : (r_sq_r >> 1);

    // divider step
    logic signed [31:0] dv_v, dv_res;
    logic [31:0]        dv_abs;
    logic               dv_ge;
    logic [15:0]        q_next;
    assign dv_v   = r_divz ? r_vz : r_vx;
    assign dv_abs = dv_v[31] ? 32'(-dv_v) : 32'(dv_v);
    assign dv_ge  = r_dv_n >= r_dv_d;
    assign q_next = {r_q[14:0], dv_ge};
    assign dv_res = dv_v[31] ? -$signed(32'(q_next)) : $signed(32'(q_next));

    // final clamp and motion test
    logic signed [15:0] fin_x, fin_z, fin_ax, fin_az;
    assign fin_x  = sat14(r_ox);
    assign fin_z  = sat14(r_oz);
    assign fin_ax = fin_x[15] ? -fin_x : fin_x;
    assign fin_az = fin_z[15] ? -fin_z : fin_z;

    // query answer from current state
    logic signed [15:0] stk_x, stk_y;
    logic [15:0]        stk_ax, stk_ay;
    t_out_word          q_word;
    logic               q_cancel;

    assign stk_x  = $signed(i_in_word.stick_in[15:0]);
    assign stk_y  = $signed(i_in_word.stick_in[31:16]);
    assign stk_ax = stk_x[15] ? 16'(-stk_x) : 16'(stk_x);
    assign stk_ay = stk_y[15] ? 16'(-stk_y) : 16'(stk_y);

    always_comb begin
        q_word   = '0;
        q_cancel = 1'b0;
        if (r_conn) begin
            if (r_moving) begin
                q_word.override = 1'b1;
                q_word.stick_x  = r_held_x;
                q_word.stick_y  = r_held_y;
            end else if (r_stop != 8'd0) begin
                if (stk_ax < {1'b0, r_idle_th} && stk_ay < {1'b0, r_idle_th}) begin
                    q_word.override = 1'b1;
                end else begin
                    q_cancel = 1'b1;
                end
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_hold_frames <= HOLD_FRAMES_RST;
            r_move_th     <= MOVE_TH_RST;
            r_idle_th     <= IDLE_TH_RST;
            r_cal_win     <= CAL_WINDOW_RST;
            r_yaw_corr    <= '0;
            r_held_x      <= '0;
            r_held_y      <= '0;
            r_moving      <= 1'b0;
            r_stop        <= '0;
            r_conn        <= 1'b0;
            r_cal         <= 1'b0;
            r_ysel        <= 1'b0;
            r_rot2        <= 1'b0;
            r_divz        <= 1'b0;
            r_vzero       <= 1'b0;
            r_cnt         <= '0;
            r_iter        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HOLD_FRAMES: r_hold_frames <= i_cfg_data[7:0];
                    CFG_MOVE_TH:     r_move_th     <= i_cfg_data[14:0];
                    CFG_IDLE_TH:     r_idle_th     <= i_cfg_data[14:0];
                    CFG_CAL_WINDOW:  r_cal_win     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            r_prod <= mul_p;

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in <= i_in_word;
                        if (i_in_word.operation == OP_QUERY) begin
                            r_pend  <= q_word;
                            r_state <= S_QOUT;
                            if (q_cancel) begin
                                r_stop <= '0;
                            end
                        end else begin
                            r_conn <= i_in_word.connected;
                            if (!i_in_word.connected) begin
                                r_moving <= 1'b0;
                                r_stop   <= '0;
                            end else if (i_in_word.button_pressed
                                         || i_in_word.calibration_age < r_cal_win) begin
                                r_cal   <= 1'b1;
                                r_ysel  <= 1'b0;
                                r_cnt   <= '0;
                                r_state <= S_YAW;
                            end else begin
                                r_cal   <= 1'b0;
                                r_ysel  <= 1'b1;
                                r_cnt   <= '0;
                                r_state <= S_YAW;
                            end
                        end
                    end
                end

                S_QOUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                S_YAW: begin
                    r_cnt <= r_cnt + 5'd1;
                    case (r_cnt)
                        5'd1: r_acc0 <= 62'(r_prod);
                        5'd2: r_acc0 <= r_acc0 + 62'(r_prod);
                        5'd3: r_acc1 <= 62'(r_prod);
                        5'd4: r_acc1 <= r_acc1 + 62'(r_prod);
                        5'd5: begin
                            r_iter  <= '0;
                            r_vzero <= (yaw_num == 36'sd0) && (yaw_den == 36'sd0);
                            if (yaw_den < 36'sd0) begin
                                r_cx  <= -yaw_den;
                                r_cy  <= -yaw_num;
                                r_ang <= 32'h8000_0000;
                            end else begin
                                r_cx  <= yaw_den;
                                r_cy  <= yaw_num;
                                r_ang <= 32'h0000_0000;
                            end
                            r_state <= S_VEC;
                        end
                        default: ;
                    endcase
                end

                S_VEC: begin
                    if (!r_vzero) begin
                        r_cx   <= c_nx;
                        r_cy   <= c_ny;
                        r_ang  <= c_na;
                        r_iter <= r_iter + 1'b1;
                    end
                    if (r_vzero || r_iter == ITER_LAST) begin
                        if (r_cal) begin
                            if (!r_ysel) begin
                                r_yb    <= vang;
                                r_ysel  <= 1'b1;
                                r_cnt   <= '0;
                                r_state <= S_YAW;
                            end else begin
                                r_yaw_corr <= 16'((r_yb - vang + 32'h0000_8000) >> 16);
                                r_held_x   <= '0;
                                r_held_y   <= '0;
                                r_moving   <= 1'b1;
                                r_state    <= S_IDLE;
                            end
                        end else begin
                            r_yh    <= vang;
                            r_cx    <= rot_x;
                            r_cy    <= rot_y;
                            r_ang   <= rot_ang;
                            r_iter  <= '0;
                            r_rot2  <= 1'b0;
                            r_state <= S_ROT;
                        end
                    end
                end

                S_ROT: begin
                    r_cx   <= c_nx;
                    r_cy   <= c_ny;
                    r_ang  <= c_na;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_GAIN;
                    end
                end

                S_GAIN: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_vx <= 32'((r_prod + 66'sd32768) >>> 16);
                    end
                    if (r_cnt == 5'd2) begin
                        r_vz    <= 32'((r_prod + 66'sd32768) >>> 16);
                        r_cnt   <= '0;
                        r_state <= r_rot2 ? S_MAG : S_MAT;
                    end
                end

                S_MAT: begin
                    r_cnt <= r_cnt + 5'd1;
                    case (r_cnt)
                        5'd0: begin
                            r_c00 <= 34'sh1000_0000;
                            r_c22 <= 34'sh1000_0000;
                            r_c01 <= '0;
                            r_c02 <= '0;
                            r_c20 <= '0;
                            r_c21 <= '0;
                        end
                        5'd1: r_c22 <= r_c22 - p2;
                        5'd2: begin
                            r_c00 <= r_c00 - p2;
                            r_c22 <= r_c22 - p2;
                        end
                        5'd3: r_c00 <= r_c00 - p2;
                        5'd4: r_c01 <= r_c01 + p2;
                        5'd5: begin
                            r_c02 <= r_c02 + p2;
                            r_c20 <= r_c20 + p2;
                        end
                        5'd6: r_c21 <= r_c21 + p2;
                        5'd7: r_c21 <= r_c21 + p2;
                        5'd8: begin
                            r_c02 <= r_c02 + p2;
                            r_c20 <= r_c20 - p2;
                        end
                        5'd9:  r_c01 <= r_c01 - p2;
                        5'd10: r_acc0 <= 62'(r_prod);
                        5'd11: r_acc0 <= r_acc0 + 62'(r_prod);
                        5'd12: r_acc0 <= r_acc0 + 62'(r_prod);
                        5'd13: r_acc1 <= 62'(r_prod);
                        5'd14: r_acc1 <= r_acc1 + 62'(r_prod);
                        5'd15: r_acc1 <= r_acc1 + 62'(r_prod);
                        5'd16: begin
                            r_cx    <= rot_x;
                            r_cy    <= rot_y;
                            r_ang   <= rot_ang;
                            r_iter  <= '0;
                            r_rot2  <= 1'b1;
                            r_state <= S_ROT;
                        end
                        default: ;
                    endcase
                end

                S_MAG: begin
                    r_cnt <= r_cnt + 5'd1;
                    case (r_cnt)
                        5'd1: r_mag <= r_prod[62:0];
                        5'd2: r_mag <= r_mag + r_prod[62:0];
                        5'd3: begin
                            if (r_mag > (63'd1 << 40)) begin
                                r_sq_n  <= r_mag;
                                r_sq_r  <= '0;
                                r_sq_b  <= 63'd1 << 62;
                                r_state <= S_SQRT;
                            end else begin
                                r_ox    <= (r_vx + 32'sd32) >>> 6;
                                r_oz    <= (r_vz + 32'sd32) >>> 6;
                                r_state <= S_FIN;
                            end
                        end
                        default: ;
                    endcase
                end

                S_SQRT: begin
                    if (sq_ge) begin
                        r_sq_n <= r_sq_n - sq_t;
                    end
                    r_sq_r <= sq_r_next;
                    r_sq_b <= r_sq_b >> 2;
                    if (r_sq_b[0]) begin
                        r_cnt   <= '0;
                        r_divz  <= 1'b0;
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    if (r_cnt == 5'd0) begin
                        r_dv_n <= 47'(dv_abs) << 14;
                        r_dv_d <= 47'(r_sq_r[31:0]) << 15;
                        r_q    <= '0;
                        r_cnt  <= 5'd1;
                    end else begin
                        if (dv_ge) begin
                            r_dv_n <= r_dv_n - r_dv_d;
                        end
                        r_dv_d <= r_dv_d >> 1;
                        r_q    <= q_next;
                        r_cnt  <= r_cnt + 5'd1;
                        if (r_cnt == 5'd16) begin
                            r_cnt <= '0;
                            if (!r_divz) begin
                                r_ox   <= dv_res;
                                r_divz <= 1'b1;
                            end else begin
                                r_oz    <= dv_res;
                                r_state <= S_FIN;
                            end
                        end
                    end
                end

                S_FIN: begin
                    r_held_x <= fin_x;
                    r_held_y <= fin_z;
                    if (fin_ax > $signed({1'b0, r_move_th})
                        || fin_az > $signed({1'b0, r_move_th})) begin
                        r_moving <= 1'b1;
                        r_stop   <= r_hold_frames;
                    end else begin
                        r_moving <= 1'b0;
                        if (r_stop != 8'd0) begin
                            r_stop <= r_stop - 8'd1;
                        end
                    end
                    r_state <= S_IDLE;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
